@@ design/assert_macros.svh @@
// assertion helpers for the checker file acl_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ACL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acl assertion failed");

// next-cycle implication, held off during reset
`define ACL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acl assertion failed");

`endif

@@ design/acl_pkg.sv @@
`timescale 1ns / 1ps

package acl_pkg;

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_ERROR   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_UPPER_T = 8'h54;
  localparam logic [7:0] CHAR_LOWER_T = 8'h74;

  // per-request flags passed from the control unit down the pipeline
  typedef struct packed {
    logic line_ready;
    logic line_accepted;
    logic overflow_seen;
    logic rd_hit;
  } acl_status_t;

  function automatic logic is_a_char(input logic [7:0] c);
    return (c == CHAR_UPPER_A) || (c == CHAR_LOWER_A);
  endfunction

  function automatic logic is_t_char(input logic [7:0] c);
    return (c == CHAR_UPPER_T) || (c == CHAR_LOWER_T);
  endfunction

endpackage

@@ design/acl_if.sv @@
`timescale 1ns / 1ps

interface acl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, output op, output rx_byte, output read_index, input ready);
  modport sink (input valid, input op, input rx_byte, input read_index, output ready);
endinterface

interface acl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       line_ready;
  logic [7:0] held_length;
  logic       line_accepted;
  logic       overflow_seen;

  modport source (output valid, output read_data, output line_ready, output held_length,
                  output line_accepted, output overflow_seen, input ready);
  modport sink (input valid, input read_data, input line_ready, input held_length,
                input line_accepted, input overflow_seen, output ready);
endinterface

@@ design/at_command_line_receiver.sv @@
`timescale 1ns / 1ps
// Command line receiver for a UART byte stream.
// in_ch carries one request per accepted valid/ready beat: op selects byte
// received, receive error, read of a held line byte, or release of the held
// line. rx_byte and read_index go with op.
// out_ch returns exactly one result per request, in order: the read byte (zero
// unless a read hits the held line), the held line status and the pulses for
// line accepted and overflow.
// The line store read is registered with the request in the read stage, and the
// result register follows. A new request is taken every cycle unless out_ch
// stalls; the single line store port pair (one write, one read) sets that rate.
// Line handoff is a bank swap inside the store, so no copy is needed.
// Reset clears all control state and the pipeline; the line store is not
// cleared, as no byte is read before it is written.
// When out_ch.ready is low the result register holds, one more request can
// sit in the read stage, and then in_ch.ready drops until the result is taken.
module at_command_line_receiver #(
  parameter int LINE_BYTES = 192
) (
  input  logic      clk,
  input  logic      rst_n,
  acl_in_if.sink    in_ch,
  acl_out_if.source out_ch
);

  import acl_pkg::*;

  localparam int AW = $clog2(2*LINE_BYTES);

  logic          fire;
  logic          advance;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  acl_status_t   st;
  logic [7:0]    st_len;

  logic          s1_v_r, s1_v_nxt;
  acl_status_t   s1_st_r;
  logic [7:0]    s1_len_r;
  logic          o_v_r, o_v_nxt;
  acl_status_t   o_st_r;
  logic [7:0]    o_len_r;
  logic [7:0]    o_data_r;

  assign advance     = s1_v_r && (!o_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || advance;
  assign fire        = in_ch.valid && in_ch.ready;

  acl_ctrl #(.LINE_BYTES(LINE_BYTES)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .op          (in_ch.op),
    .rx_byte     (in_ch.rx_byte),
    .read_index  (in_ch.read_index),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .status      (st),
    .held_length (st_len)
  );

  acl_ram #(.WIDTH(8), .DEPTH(2*LINE_BYTES)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    o_v_nxt  = o_v_r;
    if (fire) begin
      s1_v_nxt = 1'b1;
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end
    if (advance) begin
      o_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      o_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_st_r  <= st;
      s1_len_r <= st_len;
    end
    if (advance) begin
      o_st_r   <= s1_st_r;
      o_len_r  <= s1_len_r;
      o_data_r <= s1_st_r.rd_hit ? rd_data : 8'd0;
    end
  end

  assign out_ch.valid         = o_v_r;
  assign out_ch.read_data     = o_data_r;
  assign out_ch.line_ready    = o_st_r.line_ready;
  assign out_ch.held_length   = o_len_r;
  assign out_ch.line_accepted = o_st_r.line_accepted;
  assign out_ch.overflow_seen = o_st_r.overflow_seen;

endmodule

@@ design/acl_ram.sv @@
`timescale 1ns / 1ps

module acl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/acl_ctrl.sv @@
`timescale 1ns / 1ps

module acl_ctrl #(
  parameter int LINE_BYTES = 192
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fire,
  input  logic [1:0]                        op,
  input  logic [7:0]                        rx_byte,
  input  logic [7:0]                        read_index,
  output logic                              wr_en,
  output logic [$clog2(2*LINE_BYTES)-1:0]   wr_addr,
  output logic [7:0]                        wr_data,
  output logic                              rd_en,
  output logic [$clog2(2*LINE_BYTES)-1:0]   rd_addr,
  output acl_pkg::acl_status_t              status,
  output logic [7:0]                        held_length
);

  import acl_pkg::*;

  localparam int CW = $clog2(LINE_BYTES);
  localparam int AW = $clog2(2*LINE_BYTES);
  localparam int IW = (CW > 8) ? CW : 8;

  logic          bank_r, bank_nxt;
  logic [CW-1:0] acnt_r, acnt_nxt;
  logic [CW-1:0] hcnt_r, hcnt_nxt;
  logic          pend_r, pend_nxt;
  logic          skiplf_r, skiplf_nxt;
  logic          disc_r, disc_nxt;
  logic          sync_r, sync_nxt;

  logic          is_term;
  logic          keep;
  logic [CW-1:0] pos;
  logic          accepted;
  logic          overflow;
  logic          rd_hit;
  logic [CW-1:0] rd_pos;
  logic [IW-1:0] idx_ext;
  logic [IW-1:0] hcnt_ext;
  logic [IW-1:0] len_ext;

  assign is_term  = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
  assign idx_ext  = IW'(read_index);
  assign hcnt_ext = IW'(hcnt_r);
  assign rd_pos   = idx_ext[CW-1:0];

  always_comb begin
    bank_nxt   = bank_r;
    acnt_nxt   = acnt_r;
    hcnt_nxt   = hcnt_r;
    pend_nxt   = pend_r;
    skiplf_nxt = skiplf_r;
    disc_nxt   = disc_r;
    sync_nxt   = sync_r;
    accepted   = 1'b0;
    overflow   = 1'b0;
    rd_hit     = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    keep       = 1'b0;
    pos        = acnt_r;
    if (fire) begin
      case (op)
        OP_BYTE: begin
          if (is_term) begin
            if (rx_byte == CHAR_LF && skiplf_r) begin
              skiplf_nxt = 1'b0;
            end else begin
              skiplf_nxt = (rx_byte == CHAR_CR);
              if (disc_r) begin
                disc_nxt = 1'b0;
                overflow = 1'b1;
              end else if (acnt_r != '0 && !pend_r &&
                           (sync_r || acnt_r >= CW'(2))) begin
                // unsynced lines only ever store "at" in the first two places
                hcnt_nxt = acnt_r;
                pend_nxt = 1'b1;
                sync_nxt = 1'b1;
                bank_nxt = ~bank_r;
                accepted = 1'b1;
              end
              acnt_nxt = '0;
            end
          end else begin
            skiplf_nxt = 1'b0;
            if (!disc_r) begin
              keep = 1'b1;
              if (!sync_r) begin
                if (acnt_r == '0) begin
                  keep = is_a_char(rx_byte);
                end else if (acnt_r == CW'(1) && !is_t_char(rx_byte)) begin
                  // restart the prefix hunt with this byte
                  acnt_nxt = '0;
                  pos      = '0;
                  keep     = is_a_char(rx_byte);
                end
              end
              if (keep) begin
                if (pos < CW'(LINE_BYTES - 1)) begin
                  wr_en    = 1'b1;
                  acnt_nxt = pos + CW'(1);
                end else begin
                  acnt_nxt = '0;
                  disc_nxt = 1'b1;
                end
              end
            end
          end
        end
        OP_ERROR: begin
          acnt_nxt = '0;
        end
        OP_READ: begin
          rd_en  = 1'b1;
          rd_hit = (idx_ext < hcnt_ext);
        end
        OP_RELEASE: begin
          pend_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign wr_data = rx_byte;
  assign wr_addr = bank_r ? (AW'(LINE_BYTES) + AW'(pos)) : AW'(pos);
  // held bank is the one not being assembled
  assign rd_addr = bank_r ? AW'(rd_pos) : (AW'(LINE_BYTES) + AW'(rd_pos));

  assign len_ext                = IW'(hcnt_nxt);
  assign held_length            = len_ext[7:0];
  assign status.line_ready      = pend_nxt;
  assign status.line_accepted   = accepted;
  assign status.overflow_seen   = overflow;
  assign status.rd_hit          = rd_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r   <= 1'b0;
      acnt_r   <= '0;
      hcnt_r   <= '0;
      pend_r   <= 1'b0;
      skiplf_r <= 1'b0;
      disc_r   <= 1'b0;
      sync_r   <= 1'b0;
    end else begin
      bank_r   <= bank_nxt;
      acnt_r   <= acnt_nxt;
      hcnt_r   <= hcnt_nxt;
      pend_r   <= pend_nxt;
      skiplf_r <= skiplf_nxt;
      disc_r   <= disc_nxt;
      sync_r   <= sync_nxt;
    end
  end

endmodule

@@ design/acl_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module acl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_line_ready,
  input logic [7:0] out_held_length,
  input logic       out_line_accepted,
  input logic       out_overflow_seen
);

  // a terminator either hands a line over or reports overflow, never both
  `ACL_ASSERT_NOW(a_pulse_excl, clk, rst_n, out_valid, !(out_line_accepted && out_overflow_seen))

  // an accepted line is pending and not empty
  `ACL_ASSERT_NOW(a_accept_held, clk, rst_n, out_valid && out_line_accepted, out_line_ready && (out_held_length != 8'd0))

  // read data only comes from a read request, which never pulses
  `ACL_ASSERT_NOW(a_read_quiet, clk, rst_n, out_valid && (out_read_data != 8'd0), !out_line_accepted && !out_overflow_seen)

  `ACL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

bind at_command_line_receiver acl_checker u_acl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_read_data     (out_ch.read_data),
  .out_line_ready    (out_ch.line_ready),
  .out_held_length   (out_ch.held_length),
  .out_line_accepted (out_ch.line_accepted),
  .out_overflow_seen (out_ch.overflow_seen)
);

@@ test/tb_at_command_line_receiver.sv @@
`timescale 1ns / 1ps

import acl_pkg::*;

localparam int LINE_BYTES = 192;

typedef struct packed {
  logic [7:0] read_data;
  logic       line_ready;
  logic [7:0] held_length;
  logic       line_accepted;
  logic       overflow_seen;
} line_result_t;

class line_scoreboard;
  bit [7:0]    store [2*LINE_BYTES];
  bit          bank;
  int unsigned asm_cnt;
  int unsigned held_cnt;
  bit          pending;
  bit          skip_lf;
  bit          dropping;
  bit          synced;

  line_result_t want_q[$];
  int errors;
  int checked;
  int lines_taken;
  int overflows;
  int read_hits;

  function void report(string msg);
    errors++;
    if (errors <= 40) $display("%0t: %s", $time, msg);
  endfunction

  function int outstanding();
    return want_q.size();
  endfunction

  // works out the result of one accepted request and advances the line state
  function void note_request(logic [1:0] op, logic [7:0] b, logic [7:0] idx);
    line_result_t r;
    bit keep;
    int base;
    bit [7:0] c0;
    bit [7:0] c1;
    r = '0;
    base = bank ? LINE_BYTES : 0;
    case (op)
      OP_BYTE: begin
        if (b == CHAR_CR || b == CHAR_LF) begin
          if (b == CHAR_LF && skip_lf) begin
            skip_lf = 1'b0;
          end else begin
            skip_lf = (b == CHAR_CR);
            if (dropping) begin
              dropping = 1'b0;
              r.overflow_seen = 1'b1;
              overflows++;
            end else if (asm_cnt > 0 && !pending) begin
              c0 = store[base];
              c1 = store[base + 1];
              if (synced || (asm_cnt >= 2 && (c0 == CHAR_UPPER_A || c0 == CHAR_LOWER_A) &&
                             (c1 == CHAR_UPPER_T || c1 == CHAR_LOWER_T))) begin
                held_cnt = asm_cnt;
                pending = 1'b1;
                synced = 1'b1;
                bank = ~bank;
                r.line_accepted = 1'b1;
                lines_taken++;
              end
            end
            asm_cnt = 0;
          end
        end else begin
          skip_lf = 1'b0;
          keep = !dropping;
          // before the first line only an a/t prefix may start assembly
          if (keep && !synced) begin
            if (asm_cnt == 0) begin
              keep = (b == CHAR_UPPER_A || b == CHAR_LOWER_A);
            end else if (asm_cnt == 1 && !(b == CHAR_UPPER_T || b == CHAR_LOWER_T)) begin
              asm_cnt = 0;
              keep = (b == CHAR_UPPER_A || b == CHAR_LOWER_A);
            end
          end
          if (keep) begin
            if (asm_cnt + 1 < LINE_BYTES) begin
              store[base + asm_cnt] = b;
              asm_cnt++;
            end else begin
              asm_cnt = 0;
              dropping = 1'b1;
            end
          end
        end
      end
      OP_ERROR: begin
        asm_cnt = 0;
      end
      OP_READ: begin
        if (idx < held_cnt) begin
          r.read_data = store[(bank ? 0 : LINE_BYTES) + idx];
          read_hits++;
        end
      end
      OP_RELEASE: begin
        pending = 1'b0;
      end
    endcase
    r.line_ready = pending;
    r.held_length = held_cnt[7:0];
    want_q.push_back(r);
  endfunction

  function void check_result(logic [7:0] data, logic rdy, logic [7:0] len, logic acc,
                             logic ovf);
    line_result_t w;
    if (want_q.size() == 0) begin
      report($sformatf("result with no request waiting: data %0h len %0d", data, len));
      return;
    end
    w = want_q.pop_front();
    checked++;
    if (data !== w.read_data)
      report($sformatf("result %0d read_data got %0h want %0h", checked, data, w.read_data));
    if (rdy !== w.line_ready)
      report($sformatf("result %0d line_ready got %0b want %0b", checked, rdy, w.line_ready));
    if (len !== w.held_length)
      report($sformatf("result %0d held_length got %0d want %0d", checked, len,
                       w.held_length));
    if (acc !== w.line_accepted)
      report($sformatf("result %0d line_accepted got %0b want %0b", checked, acc,
                       w.line_accepted));
    if (ovf !== w.overflow_seen)
      report($sformatf("result %0d overflow_seen got %0b want %0b", checked, ovf,
                       w.overflow_seen));
  endfunction
endclass

module tb_at_command_line_receiver;

  localparam int QUIET_LIMIT = 5000;
  localparam int ITEM_TARGET = 550;
  localparam int HOLD_CYCLES = 60;

  logic clk;
  logic rst_n;

  acl_in_if  in_ch();
  acl_out_if out_ch();

  line_scoreboard sb = new();

  int sent;
  int burst_left;
  bit steady;
  int hold_asked;
  int hold_done;
  int quiet;

  at_command_line_receiver #(.LINE_BYTES(LINE_BYTES)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: phases of always ready, random and patterned stalls, plus long hold-offs
  initial begin : result_sink
    bit [15:0] rx_phase;
    int hold_left;
    rx_phase = '0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_phase++;
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_done != hold_asked) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_phase[8:7])
          2'd0: out_ch.ready <= 1'b1;
          2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2'd2: out_ch.ready <= (rx_phase[2:0] < 3'd5);
          default: out_ch.ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // watch both channels, feed the scoreboard, and catch a hang
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request(in_ch.op, in_ch.rx_byte, in_ch.read_index);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.read_data, out_ch.line_ready, out_ch.held_length,
                      out_ch.line_accepted, out_ch.overflow_seen);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] op, input logic [7:0] b, input logic [7:0] idx);
    if (!steady) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.rx_byte    <= b;
    in_ch.read_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_char(input logic [7:0] b);
    send_req(OP_BYTE, b, 8'($urandom_range(0, 190)));
  endtask

  task automatic send_cmd(input logic [1:0] op, input logic [7:0] idx);
    send_req(op, 8'($urandom_range(0, 255)), idx);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  // a line of len characters with an a/t prefix, a receive error before
  // character err_at (none if out of range) and a random terminator
  task automatic send_line(input int len, input int err_at);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (i == err_at) send_cmd(OP_ERROR, 8'($urandom_range(0, 190)));
      if (i == 0)
        b = $urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A;
      else if (i == 1)
        b = $urandom_range(0, 1) ? CHAR_UPPER_T : CHAR_LOWER_T;
      else
        b = text_byte();
      send_char(b);
    end
    case ($urandom_range(0, 3))
      0: send_char(CHAR_CR);
      1: send_char(CHAR_LF);
      2: begin
        send_char(CHAR_CR);
        send_char(CHAR_LF);
      end
      default: begin
        send_char(CHAR_CR);
        send_char(CHAR_CR);
        send_char(CHAR_LF);
      end
    endcase
  endtask

  task automatic read_some(input int n);
    int unsigned idx;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        idx = $urandom_range(0, 190);
      else
        idx = $urandom_range(0, sb.held_cnt + 1);
      if (idx > 190) idx = 190;
      send_cmd(OP_READ, 8'(idx));
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int seq;
    int len;
    int pick;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_BYTE;
    in_ch.rx_byte    <= '0;
    in_ch.read_index <= '0;
    sent = 0;
    burst_left = 0;
    steady = 1'b0;
    hold_asked = 0;
    hold_done = 0;
    quiet = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // nothing held yet: read and release do nothing
    send_cmd(OP_READ, 8'd0);
    send_cmd(OP_RELEASE, 8'd0);
    // prefix hunt: junk, a lone 'A' line, LF swallowed after CR
    send_char("Z");
    send_char(CHAR_UPPER_A);
    send_char(CHAR_CR);
    send_char(CHAR_LF);
    // 'a' then a non-t restarts the hunt; 'a' 'A' 't' keeps the second a
    send_char(CHAR_LOWER_A);
    send_char("x");
    send_char(CHAR_LOWER_A);
    send_char(CHAR_UPPER_A);
    send_char(CHAR_LOWER_T);
    send_char(8'hFF);
    send_char(CHAR_CR);
    send_char(CHAR_LF);
    send_char(CHAR_LF);
    send_cmd(OP_READ, 8'd0);
    send_cmd(OP_READ, 8'd2);
    send_cmd(OP_READ, 8'd3);
    send_cmd(OP_READ, 8'd190);
    // line lost while one is still held
    send_char(8'h00);
    send_char(CHAR_LF);
    // receive error empties the partial line
    send_char("q");
    send_cmd(OP_ERROR, 8'd0);
    send_char(CHAR_CR);
    send_cmd(OP_RELEASE, 8'd0);
    // synced now: no prefix needed
    send_char(8'h00);
    send_char(8'h80);
    send_char(CHAR_LF);
    send_cmd(OP_READ, 8'd1);
    send_cmd(OP_RELEASE, 8'd0);

    seq = 0;
    while (sent < ITEM_TARGET) begin
      seq++;
      if (seq == 4) begin
        // longest line that still fits
        send_cmd(OP_RELEASE, 8'd0);
        send_line(LINE_BYTES - 1, -1);
        send_cmd(OP_READ, 8'd190);
        send_cmd(OP_READ, 8'd0);
        read_some(3);
        send_cmd(OP_RELEASE, 8'd0);
      end else if (seq == 9) begin
        // too long, and, if it runs past LINE_BYTES + 1, a receive error while the tail is dropped
        send_cmd(OP_RELEASE, 8'd0);
        send_line(LINE_BYTES + $urandom_range(0, 4), LINE_BYTES + 1);
        send_line($urandom_range(2, 8), -1);
        read_some(2);
      end else if (seq == 2 || seq == 7) begin
        // result side holds off while requests keep coming
        hold_asked++;
        steady = 1'b1;
        repeat (4) begin
          send_line($urandom_range(2, 6), -1);
          read_some(2);
          send_cmd(OP_RELEASE, 8'd0);
        end
        steady = 1'b0;
      end else if (seq == 6) begin
        drain();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 14);
          send_line(len, -1);
          read_some($urandom_range(0, 4));
          if ($urandom_range(0, 9) < 7) send_cmd(OP_RELEASE, 8'd0);
        end else if (pick < 65) begin
          len = $urandom_range(1, 12);
          send_line(len, $urandom_range(0, len));
          read_some($urandom_range(0, 2));
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 6))
            send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 190)));
        end else if (pick < 90) begin
          read_some($urandom_range(1, 5));
          send_cmd(OP_RELEASE, 8'd0);
        end else begin
          repeat ($urandom_range(1, 4))
            send_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        end
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d results never arrived", sb.outstanding()));
    $display("%0d requests, %0d results checked: %0d lines handed over, %0d too long,",
             sent, sb.checked, sb.lines_taken, sb.overflows);
    $display("%0d reads inside the held line, %0d mismatches", sb.read_hits, sb.errors);
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/acl_pkg.sv
design/acl_if.sv
design/acl_ram.sv
design/acl_ctrl.sv
design/at_command_line_receiver.sv
design/acl_checker.sv
test/tb_at_command_line_receiver.sv
